// ===== rtl/cir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cir_pkg;

    // Fixed-point one in Q16.16.
    localparam int CIR_Q_ONE = 65536;
    // Upper bound kept on the impulse denominators.
    localparam logic [47:0] CIR_DEN_CAP = 48'h8000_0000_0000;
    // Default number of entries in the queue between the front and the back.
    localparam int CIR_FIFO_DEPTH = 4;
    // Quotient bits produced by each divider, one bit per stage.
    localparam int CIR_DIV_QW = 32;

    // One decoded contact as it travels from the front to the back.
    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic [31:0]        depth;
        logic signed [31:0] pax;
        logic signed [31:0] pay;
        logic signed [31:0] pbx;
        logic signed [31:0] pby;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] vax;
        logic signed [31:0] vay;
        logic signed [31:0] vbx;
        logic signed [31:0] vby;
        logic signed [31:0] wa;
        logic signed [31:0] wb;
        logic [31:0]        ma;
        logic [31:0]        mb;
        logic [31:0]        ia;
        logic [31:0]        ib;
        logic [15:0]        emin;
        logic [15:0]        fmin;
        logic [32:0]        sum;
        logic               flag;
    } ctx_t;

    // Queue status seen by the top level.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

`default_nettype wire

// ===== rtl/cir_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cir_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [63:0]     s_normal_xy,
    input  logic [31:0]     s_depth,
    input  logic [63:0]     s_point_a_xy,
    input  logic [63:0]     s_point_b_xy,
    input  logic [63:0]     s_pos_a_xy,
    input  logic [63:0]     s_pos_b_xy,
    input  logic [63:0]     s_vel_a_xy,
    input  logic [63:0]     s_vel_b_xy,
    input  logic [63:0]     s_ang_vel_ab,
    input  logic [63:0]     s_inv_mass_ab,
    input  logic [63:0]     s_inv_inertia_ab,
    input  logic [63:0]     s_material_coeffs,
    output logic            out_valid,
    output cir_pkg::ctx_t   out_ctx,
    input  logic            out_ready
);
    import cir_pkg::*;

    logic vld_reg, vld_next;
    ctx_t ctx_reg, ctx_next;
    logic accept;

    assign s_ready   = !vld_reg || out_ready;
    assign accept    = s_valid && s_ready;
    assign out_valid = vld_reg;
    assign out_ctx   = ctx_reg;

    always_comb begin
        ctx_next.nx    = $signed(s_normal_xy[63:32]);
        ctx_next.ny    = $signed(s_normal_xy[31:0]);
        ctx_next.depth = s_depth;
        ctx_next.pax   = $signed(s_point_a_xy[63:32]);
        ctx_next.pay   = $signed(s_point_a_xy[31:0]);
        ctx_next.pbx   = $signed(s_point_b_xy[63:32]);
        ctx_next.pby   = $signed(s_point_b_xy[31:0]);
        ctx_next.ax    = $signed(s_pos_a_xy[63:32]);
        ctx_next.ay    = $signed(s_pos_a_xy[31:0]);
        ctx_next.bx    = $signed(s_pos_b_xy[63:32]);
        ctx_next.by    = $signed(s_pos_b_xy[31:0]);
        ctx_next.vax   = $signed(s_vel_a_xy[63:32]);
        ctx_next.vay   = $signed(s_vel_a_xy[31:0]);
        ctx_next.vbx   = $signed(s_vel_b_xy[63:32]);
        ctx_next.vby   = $signed(s_vel_b_xy[31:0]);
        ctx_next.wa    = $signed(s_ang_vel_ab[63:32]);
        ctx_next.wb    = $signed(s_ang_vel_ab[31:0]);
        ctx_next.ma    = s_inv_mass_ab[63:32];
        ctx_next.mb    = s_inv_mass_ab[31:0];
        ctx_next.ia    = s_inv_inertia_ab[63:32];
        ctx_next.ib    = s_inv_inertia_ab[31:0];
        // Smaller restitution and smaller friction of the pair.
        ctx_next.emin  = (s_material_coeffs[63:48] < s_material_coeffs[47:32]) ?
                         s_material_coeffs[63:48] : s_material_coeffs[47:32];
        ctx_next.fmin  = (s_material_coeffs[31:16] < s_material_coeffs[15:0]) ?
                         s_material_coeffs[31:16] : s_material_coeffs[15:0];
        ctx_next.sum   = {1'b0, s_inv_mass_ab[63:32]} + {1'b0, s_inv_mass_ab[31:0]};
        ctx_next.flag  = (s_inv_mass_ab == 64'd0);
        vld_next = vld_reg;
        if (accept) begin
            vld_next = 1'b1;
        end else if (out_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ctx_reg <= ctx_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cir_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cir_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cir_pkg::ctx_t        in_ctx,
    output logic                 out_valid,
    output cir_pkg::ctx_t        out_ctx,
    input  logic                 out_ready,
    output cir_pkg::fifo_stat_t  stat
);
    import cir_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ctx_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          push, pop;

    assign stat.full  = (cnt_reg == CW'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign in_ready   = !stat.full;
    assign out_valid  = !stat.empty;
    assign out_ctx    = mem_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = out_ready && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_ctx;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cir_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage. The upper dividend bits
// above the quotient must be smaller than the divisor.
module cir_div #(
    parameter int DW = 64,
    parameter int VW = 33,
    parameter int QW = 32
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic [QW-1:0] quotient
);

    logic [VW-1:0] r_reg  [QW];
    logic [QW-1:0] lo_reg [QW];
    logic [VW-1:0] d_reg  [QW];

    for (genvar g = 0; g < QW; g++) begin : g_st
        logic [VW-1:0] r_in, d_in, r_next;
        logic [QW-1:0] lo_in, lo_next;
        logic [VW:0]   t;
        logic          ge;
        if (g == 0) begin : g_first
            assign r_in  = VW'(dividend[DW-1:QW]);
            assign lo_in = dividend[QW-1:0];
            assign d_in  = divisor;
        end else begin : g_rest
            assign r_in  = r_reg[g-1];
            assign lo_in = lo_reg[g-1];
            assign d_in  = d_reg[g-1];
        end
        assign t       = {r_in, lo_in[QW-1]};
        assign ge      = (t >= {1'b0, d_in});
        assign r_next  = ge ? VW'(t - {1'b0, d_in}) : t[VW-1:0];
        assign lo_next = {lo_in[QW-2:0], ge};
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[g]  <= r_next;
                lo_reg[g] <= lo_next;
                d_reg[g]  <= d_in;
            end
        end
    end

    assign quotient = lo_reg[QW-1];

endmodule

`default_nettype wire

// ===== rtl/cir_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cir_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  cir_pkg::ctx_t      in_ctx,
    output logic               in_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_new_pos_a_x,
    output logic signed [31:0] m_new_pos_a_y,
    output logic signed [31:0] m_new_pos_b_x,
    output logic signed [31:0] m_new_pos_b_y,
    output logic signed [31:0] m_impulse_x,
    output logic signed [31:0] m_impulse_y,
    output logic               m_both_static
);
    import cir_pkg::*;

    localparam int LAT = 2 * CIR_DIV_QW + 15;

    typedef struct packed {
        ctx_t               c;
        logic [63:0]        pa;
        logic [63:0]        pb;
        logic [31:0]        da;
        logic [31:0]        db;
        logic signed [63:0] pnxa;
        logic signed [63:0] pnya;
        logic signed [63:0] pnxb;
        logic signed [63:0] pnyb;
        logic signed [31:0] npax;
        logic signed [31:0] npay;
        logic signed [31:0] npbx;
        logic signed [31:0] npby;
        logic [18:0]        e1;
        logic [17:0]        f4;
        logic signed [31:0] rax;
        logic signed [31:0] ray;
        logic signed [31:0] rbx;
        logic signed [31:0] rby;
        logic signed [31:0] k;
        logic signed [31:0] tx;
        logic signed [63:0] p_wary;
        logic signed [63:0] p_warx;
        logic signed [63:0] p_wbry;
        logic signed [63:0] p_wbrx;
        logic signed [63:0] pc0;
        logic signed [63:0] pc1;
        logic signed [63:0] pc2;
        logic signed [63:0] pc3;
        logic signed [63:0] pc4;
        logic signed [63:0] pc5;
        logic signed [63:0] pc6;
        logic signed [63:0] pc7;
        logic signed [31:0] mwary;
        logic signed [31:0] mwarx;
        logic signed [31:0] mwbry;
        logic signed [31:0] mwbrx;
        logic signed [31:0] can;
        logic signed [31:0] cbn;
        logic signed [31:0] cat;
        logic signed [31:0] cbt;
        logic signed [31:0] rvx;
        logic signed [31:0] rvy;
        logic [3:0][31:0]   mg;
        logic signed [63:0] pvn1;
        logic signed [63:0] pvn2;
        logic signed [63:0] pvt1;
        logic signed [63:0] pvt2;
        logic [3:0][63:0]   sq;
        logic signed [31:0] vn;
        logic signed [31:0] vt;
        logic [3:0][46:0]   arm;
        logic signed [63:0] pen;
        logic signed [63:0] pet;
        logic [3:0][55:0]   plo;
        logic [3:0][54:0]   phi;
        logic signed [31:0] numn;
        logic signed [31:0] numt;
        logic [3:0][47:0]   term;
        logic [47:0]        denn;
        logic [47:0]        dent;
        logic [47:0]        magn;
        logic [47:0]        magt;
        logic               negn;
        logic               negt;
        logic               ovfn;
        logic               ovft;
        logic signed [31:0] jn;
        logic signed [31:0] jt;
        logic signed [63:0] pix1;
        logic signed [63:0] pix2;
        logic signed [63:0] piy1;
        logic signed [63:0] piy2;
        logic signed [31:0] ix;
        logic signed [31:0] iy;
    } work_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Floor shift by 16 of a wrapped 64-bit sum, then saturate.
    function automatic logic signed [31:0] asr_sat(input logic signed [63:0] v);
        logic signed [63:0] s;
        s = v >>> 16;
        return sat32(66'(s));
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [47:0] satadd(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] r;
        r = {1'b0, a} + {1'b0, b};
        return (r > {1'b0, CIR_DEN_CAP}) ? CIR_DEN_CAP : r[47:0];
    endfunction

    function automatic logic signed [31:0] qsel(input logic [31:0] q, input logic neg,
                                                input logic ovf);
        if (ovf) begin
            return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else if (neg) begin
            return (q > 32'h8000_0000) ? 32'sh8000_0000 : $signed(32'd0 - q);
        end
        return (q > 32'h7fff_ffff) ? 32'sh7fff_ffff : $signed(q);
    endfunction

    logic [LAT-1:0] vld_reg, vld_next;
    logic           adv;
    work_t s1_reg, s1_next, s2_reg, s2_next, s3_reg, s3_next, s4_reg, s4_next;
    work_t s5_reg, s5_next, s6_reg, s6_next, s7_reg, s7_next, s8_reg, s8_next;
    work_t s9_reg, s9_next, s10_reg, s10_next, s11_reg, s11_next;
    work_t s12_reg, s12_next, s13_reg, s13_next, s14_reg, s14_next;
    work_t s15_reg, s15_next;
    work_t dl1_reg [CIR_DIV_QW];
    work_t dl2_reg [CIR_DIV_QW];
    logic [31:0] qa, qb, qn, qt;

    assign adv      = !vld_reg[LAT-1] || m_ready;
    assign in_ready = adv;
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    cir_div #(.DW(64), .VW(33), .QW(CIR_DIV_QW)) u_div_a (
        .aclk(aclk), .en(adv), .dividend(s1_reg.pa), .divisor(s1_reg.c.sum), .quotient(qa)
    );
    cir_div #(.DW(64), .VW(33), .QW(CIR_DIV_QW)) u_div_b (
        .aclk(aclk), .en(adv), .dividend(s1_reg.pb), .divisor(s1_reg.c.sum), .quotient(qb)
    );
    cir_div #(.DW(48), .VW(48), .QW(CIR_DIV_QW)) u_div_n (
        .aclk(aclk), .en(adv), .dividend(s12_reg.magn), .divisor(s12_reg.denn),
        .quotient(qn)
    );
    cir_div #(.DW(48), .VW(48), .QW(CIR_DIV_QW)) u_div_t (
        .aclk(aclk), .en(adv), .dividend(s12_reg.magt), .divisor(s12_reg.dent),
        .quotient(qt)
    );

    always_comb begin
        logic [36:0] kp;
        logic [79:0] full;
        logic [63:0] sh;
        logic [31:0] inert;

        // Depth times each inverse mass.
        s1_next    = '0;
        s1_next.c  = in_ctx;
        s1_next.pa = in_ctx.depth * in_ctx.ma;
        s1_next.pb = in_ctx.depth * in_ctx.mb;

        // Depth shares back from the dividers; normal times each share.
        s2_next      = dl1_reg[CIR_DIV_QW-1];
        s2_next.da   = qa;
        s2_next.db   = qb;
        s2_next.pnxa = s2_next.c.nx * $signed({1'b0, qa});
        s2_next.pnya = s2_next.c.ny * $signed({1'b0, qa});
        s2_next.pnxb = s2_next.c.nx * $signed({1'b0, qb});
        s2_next.pnyb = s2_next.c.ny * $signed({1'b0, qb});

        // Corrected positions; a static pair keeps its positions.
        s3_next = s2_reg;
        if (s2_reg.c.flag) begin
            s3_next.npax = s2_reg.c.ax;
            s3_next.npay = s2_reg.c.ay;
            s3_next.npbx = s2_reg.c.bx;
            s3_next.npby = s2_reg.c.by;
        end else begin
            s3_next.npax = sat32(66'(s2_reg.c.ax) - 66'(s2_reg.pnxa >>> 16));
            s3_next.npay = sat32(66'(s2_reg.c.ay) - 66'(s2_reg.pnya >>> 16));
            s3_next.npbx = sat32(66'(s2_reg.c.bx) + 66'(s2_reg.pnxb >>> 16));
            s3_next.npby = sat32(66'(s2_reg.c.by) + 66'(s2_reg.pnyb >>> 16));
        end
        s3_next.e1 = 19'(CIR_Q_ONE) + {1'b0, s2_reg.c.emin, 2'b00};
        s3_next.f4 = {s2_reg.c.fmin, 2'b00};

        // Contact arms, friction factor and tangent.
        s4_next     = s3_reg;
        s4_next.rax = sat32(66'(s3_reg.c.pax) - 66'(s3_reg.npax));
        s4_next.ray = sat32(66'(s3_reg.c.pay) - 66'(s3_reg.npay));
        s4_next.rbx = sat32(66'(s3_reg.c.pbx) - 66'(s3_reg.npbx));
        s4_next.rby = sat32(66'(s3_reg.c.pby) - 66'(s3_reg.npby));
        kp          = s3_reg.f4 * s3_reg.e1;
        s4_next.k   = $signed(32'(kp >> 16));
        s4_next.tx  = sat32(-66'(s3_reg.c.ny));

        // Angular and cross products.
        s5_next        = s4_reg;
        s5_next.p_wary = s4_reg.c.wa * s4_reg.ray;
        s5_next.p_warx = s4_reg.c.wa * s4_reg.rax;
        s5_next.p_wbry = s4_reg.c.wb * s4_reg.rby;
        s5_next.p_wbrx = s4_reg.c.wb * s4_reg.rbx;
        s5_next.pc0    = s4_reg.rax * s4_reg.c.ny;
        s5_next.pc1    = s4_reg.ray * s4_reg.c.nx;
        s5_next.pc2    = s4_reg.rbx * s4_reg.c.ny;
        s5_next.pc3    = s4_reg.rby * s4_reg.c.nx;
        s5_next.pc4    = s4_reg.rax * s4_reg.c.nx;
        s5_next.pc5    = s4_reg.ray * s4_reg.tx;
        s5_next.pc6    = s4_reg.rbx * s4_reg.c.nx;
        s5_next.pc7    = s4_reg.rby * s4_reg.tx;

        s6_next       = s5_reg;
        s6_next.mwary = asr_sat(s5_reg.p_wary);
        s6_next.mwarx = asr_sat(s5_reg.p_warx);
        s6_next.mwbry = asr_sat(s5_reg.p_wbry);
        s6_next.mwbrx = asr_sat(s5_reg.p_wbrx);
        s6_next.can   = asr_sat(s5_reg.pc0 - s5_reg.pc1);
        s6_next.cbn   = asr_sat(s5_reg.pc2 - s5_reg.pc3);
        s6_next.cat   = asr_sat(s5_reg.pc4 - s5_reg.pc5);
        s6_next.cbt   = asr_sat(s5_reg.pc6 - s5_reg.pc7);

        // Relative point velocity and cross magnitudes.
        s7_next     = s6_reg;
        s7_next.rvx = sat32(66'(sat32(66'(s6_reg.c.vax) - 66'(s6_reg.mwary)))
                          - 66'(sat32(66'(s6_reg.c.vbx) - 66'(s6_reg.mwbry))));
        s7_next.rvy = sat32(66'(sat32(66'(s6_reg.c.vay) + 66'(s6_reg.mwarx)))
                          - 66'(sat32(66'(s6_reg.c.vby) + 66'(s6_reg.mwbrx))));
        s7_next.mg[0] = abs32(s6_reg.can);
        s7_next.mg[1] = abs32(s6_reg.cbn);
        s7_next.mg[2] = abs32(s6_reg.cat);
        s7_next.mg[3] = abs32(s6_reg.cbt);

        s8_next      = s7_reg;
        s8_next.pvn1 = s7_reg.rvx * s7_reg.c.nx;
        s8_next.pvn2 = s7_reg.rvy * s7_reg.c.ny;
        s8_next.pvt1 = s7_reg.rvx * s7_reg.tx;
        s8_next.pvt2 = s7_reg.rvy * s7_reg.c.nx;
        for (int i = 0; i < 4; i++) begin
            s8_next.sq[i] = s7_reg.mg[i] * s7_reg.mg[i];
        end

        s9_next    = s8_reg;
        s9_next.vn = asr_sat(s8_reg.pvn1 + s8_reg.pvn2);
        s9_next.vt = asr_sat(s8_reg.pvt1 + s8_reg.pvt2);
        for (int i = 0; i < 4; i++) begin
            s9_next.arm[i] = 47'(s8_reg.sq[i] >> 16);
        end

        // Arm terms are split into two partial products against the inertia.
        s10_next     = s9_reg;
        s10_next.pen = $signed({1'b0, s9_reg.e1}) * s9_reg.vn;
        s10_next.pet = s9_reg.k * s9_reg.vt;
        for (int i = 0; i < 4; i++) begin
            inert = i[0] ? s9_reg.c.ib : s9_reg.c.ia;
            s10_next.plo[i] = s9_reg.arm[i][23:0] * inert;
            s10_next.phi[i] = s9_reg.arm[i][46:24] * inert;
        end

        s11_next      = s10_reg;
        s11_next.numn = sat32(-66'(asr_sat(s10_reg.pen)));
        s11_next.numt = sat32(-66'(asr_sat(s10_reg.pet)));
        for (int i = 0; i < 4; i++) begin
            full = ({25'd0, s10_reg.phi[i]} << 24) + {24'd0, s10_reg.plo[i]};
            sh   = full[79:16];
            s11_next.term[i] = (sh > 64'(CIR_DEN_CAP)) ? CIR_DEN_CAP : sh[47:0];
        end

        // Denominators, dividend magnitudes and quotient overflow.
        s12_next      = s11_reg;
        s12_next.denn = satadd(satadd(48'(s11_reg.c.sum), s11_reg.term[0]),
                               s11_reg.term[1]);
        s12_next.dent = satadd(satadd(48'(s11_reg.c.sum), s11_reg.term[2]),
                               s11_reg.term[3]);
        s12_next.magn = {abs32(s11_reg.numn), 16'd0};
        s12_next.magt = {abs32(s11_reg.numt), 16'd0};
        s12_next.negn = s11_reg.numn[31];
        s12_next.negt = s11_reg.numt[31];
        s12_next.ovfn = (48'(s12_next.magn[47:32]) >= s12_next.denn);
        s12_next.ovft = (48'(s12_next.magt[47:32]) >= s12_next.dent);

        s13_next    = dl2_reg[CIR_DIV_QW-1];
        s13_next.jn = qsel(qn, s13_next.negn, s13_next.ovfn);
        s13_next.jt = qsel(qt, s13_next.negt, s13_next.ovft);

        s14_next      = s13_reg;
        s14_next.pix1 = s13_reg.c.nx * s13_reg.jn;
        s14_next.pix2 = s13_reg.tx * s13_reg.jt;
        s14_next.piy1 = s13_reg.c.ny * s13_reg.jn;
        s14_next.piy2 = s13_reg.c.nx * s13_reg.jt;

        s15_next = s14_reg;
        if (s14_reg.c.flag) begin
            s15_next.ix = '0;
            s15_next.iy = '0;
        end else begin
            s15_next.ix = sat32(66'(asr_sat(s14_reg.pix1)) + 66'(asr_sat(s14_reg.pix2)));
            s15_next.iy = sat32(66'(asr_sat(s14_reg.piy1)) + 66'(asr_sat(s14_reg.piy2)));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg     <= s1_next;
            dl1_reg[0] <= s1_reg;
            for (int i = 1; i < CIR_DIV_QW; i++) begin
                dl1_reg[i] <= dl1_reg[i-1];
            end
            s2_reg     <= s2_next;
            s3_reg     <= s3_next;
            s4_reg     <= s4_next;
            s5_reg     <= s5_next;
            s6_reg     <= s6_next;
            s7_reg     <= s7_next;
            s8_reg     <= s8_next;
            s9_reg     <= s9_next;
            s10_reg    <= s10_next;
            s11_reg    <= s11_next;
            s12_reg    <= s12_next;
            dl2_reg[0] <= s12_reg;
            for (int i = 1; i < CIR_DIV_QW; i++) begin
                dl2_reg[i] <= dl2_reg[i-1];
            end
            s13_reg    <= s13_next;
            s14_reg    <= s14_next;
            s15_reg    <= s15_next;
        end
    end

    assign m_valid       = vld_reg[LAT-1];
    assign m_new_pos_a_x = s15_reg.npax;
    assign m_new_pos_a_y = s15_reg.npay;
    assign m_new_pos_b_x = s15_reg.npbx;
    assign m_new_pos_b_y = s15_reg.npby;
    assign m_impulse_x   = s15_reg.ix;
    assign m_impulse_y   = s15_reg.iy;
    assign m_both_static = s15_reg.c.flag;

endmodule

`default_nettype wire

// ===== rtl/contact_impulse_resolver_top.sv =====
// An accepted item passes through the front register, the queue and the
// 79 back stages, of which two sets of 32 stages are the bit-per-stage
// dividers.
// Throughput: one item per cycle, sustained while m_ready stays high.
// Reset: aresetn is synchronous and active low; it empties the queue and
// clears every valid bit, and the datapath registers keep no reset.
`timescale 1ns / 1ps
`default_nettype none

module contact_impulse_resolver_top #(
    parameter int FIFO_DEPTH = cir_pkg::CIR_FIFO_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [63:0]        s_normal_xy,
    input  logic [31:0]        s_depth,
    input  logic [63:0]        s_point_a_xy,
    input  logic [63:0]        s_point_b_xy,
    input  logic [63:0]        s_pos_a_xy,
    input  logic [63:0]        s_pos_b_xy,
    input  logic [63:0]        s_vel_a_xy,
    input  logic [63:0]        s_vel_b_xy,
    input  logic [63:0]        s_ang_vel_ab,
    input  logic [63:0]        s_inv_mass_ab,
    input  logic [63:0]        s_inv_inertia_ab,
    input  logic [63:0]        s_material_coeffs,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_new_pos_a_x,
    output logic signed [31:0] m_new_pos_a_y,
    output logic signed [31:0] m_new_pos_b_x,
    output logic signed [31:0] m_new_pos_b_y,
    output logic signed [31:0] m_impulse_x,
    output logic signed [31:0] m_impulse_y,
    output logic               m_both_static
);
    import cir_pkg::*;

    // The front registers each item, unpacks its fields and works out the
    // inverse mass sum and the both-static flag.
    logic       front_valid, front_ready;
    ctx_t       front_ctx;

    // The queue lets the front keep taking items while the back is stalled
    // by the result side.
    logic       q_valid, q_ready;
    ctx_t       q_ctx;
    fifo_stat_t fifo_stat;

    cir_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_normal_xy(s_normal_xy), .s_depth(s_depth),
        .s_point_a_xy(s_point_a_xy), .s_point_b_xy(s_point_b_xy),
        .s_pos_a_xy(s_pos_a_xy), .s_pos_b_xy(s_pos_b_xy),
        .s_vel_a_xy(s_vel_a_xy), .s_vel_b_xy(s_vel_b_xy),
        .s_ang_vel_ab(s_ang_vel_ab), .s_inv_mass_ab(s_inv_mass_ab),
        .s_inv_inertia_ab(s_inv_inertia_ab), .s_material_coeffs(s_material_coeffs),
        .out_valid(front_valid), .out_ctx(front_ctx), .out_ready(front_ready)
    );

    cir_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(front_valid), .in_ready(front_ready), .in_ctx(front_ctx),
        .out_valid(q_valid), .out_ctx(q_ctx), .out_ready(q_ready),
        .stat(fifo_stat)
    );

    // The back is one pipeline that advances as a whole whenever its output
    // register is empty or being read; the last stage is the result register.
    cir_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ctx(q_ctx), .in_ready(q_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_new_pos_a_x(m_new_pos_a_x), .m_new_pos_a_y(m_new_pos_a_y),
        .m_new_pos_b_x(m_new_pos_b_x), .m_new_pos_b_y(m_new_pos_b_y),
        .m_impulse_x(m_impulse_x), .m_impulse_y(m_impulse_y),
        .m_both_static(m_both_static)
    );

    // A static pair never carries an impulse.
    a_static_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_both_static |-> m_impulse_x == '0 && m_impulse_y == '0)
        else $error("static contact produced a nonzero impulse");

    // The input side only backs up when the front holds an item and the
    // queue is full.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> front_valid && fifo_stat.full)
        else $error("input stalled without a full queue");

    // A full queue can never also read as empty.
    a_fifo_count: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_stat.full |-> !fifo_stat.empty)
        else $error("queue status inconsistent");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int N_RANDOM    = 1130;
    localparam int CYCLE_LIMIT = 400000;
    localparam int CALM_TAIL   = 150;    // items at the end sent with no idling
    localparam int SETTLE      = 120;    // cycles after the last result
    localparam int HOLD_AT     = 300;    // accepted count that starts the long stall
    localparam int HOLD_LEN    = 400;
    localparam int DRAIN_AT    = 700;    // item that waits until all results are in
    localparam longint DEN_CAP = 64'h0000_8000_0000_0000;

    // One contact as it is offered on the input channel.
    typedef struct {
        logic [63:0] normal_xy;
        logic [31:0] depth;
        logic [63:0] point_a_xy;
        logic [63:0] point_b_xy;
        logic [63:0] pos_a_xy;
        logic [63:0] pos_b_xy;
        logic [63:0] vel_a_xy;
        logic [63:0] vel_b_xy;
        logic [63:0] ang_vel_ab;
        logic [63:0] inv_mass_ab;
        logic [63:0] inv_inertia_ab;
        logic [63:0] material_coeffs;
        bit          wait_drain;
    } contact_t;

    // Corrected positions and impulse for one contact.
    typedef struct {
        logic [31:0] pax, pay, pbx, pby, jx, jy;
        logic        both_static;
    } response_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [63:0] s_normal_xy = '0, s_point_a_xy = '0, s_point_b_xy = '0;
    logic [63:0] s_pos_a_xy = '0, s_pos_b_xy = '0, s_vel_a_xy = '0, s_vel_b_xy = '0;
    logic [63:0] s_ang_vel_ab = '0, s_inv_mass_ab = '0, s_inv_inertia_ab = '0;
    logic [63:0] s_material_coeffs = '0;
    logic [31:0] s_depth = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_new_pos_a_x, m_new_pos_a_y, m_new_pos_b_x, m_new_pos_b_y;
    logic signed [31:0] m_impulse_x, m_impulse_y;
    logic m_both_static;

    contact_impulse_resolver_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_normal_xy(s_normal_xy), .s_depth(s_depth),
        .s_point_a_xy(s_point_a_xy), .s_point_b_xy(s_point_b_xy),
        .s_pos_a_xy(s_pos_a_xy), .s_pos_b_xy(s_pos_b_xy),
        .s_vel_a_xy(s_vel_a_xy), .s_vel_b_xy(s_vel_b_xy),
        .s_ang_vel_ab(s_ang_vel_ab), .s_inv_mass_ab(s_inv_mass_ab),
        .s_inv_inertia_ab(s_inv_inertia_ab), .s_material_coeffs(s_material_coeffs),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_new_pos_a_x(m_new_pos_a_x), .m_new_pos_a_y(m_new_pos_a_y),
        .m_new_pos_b_x(m_new_pos_b_x), .m_new_pos_b_y(m_new_pos_b_y),
        .m_impulse_x(m_impulse_x), .m_impulse_y(m_impulse_y),
        .m_both_static(m_both_static)
    );

    always #10 aclk = ~aclk;

    contact_t  pending_contacts[$];
    response_t expected_responses[$];
    contact_t  current;
    int  total_items = 0;
    int  accepted = 0;
    int  mismatches = 0;
    int  cycles = 0;
    bit  in_fire = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    // ------------------------------------------------------------------
    // Fixed-point helpers. All intermediate math is done in 64 bits and
    // wraps exactly like the two's-complement arithmetic of the design.
    // ------------------------------------------------------------------
    function automatic longint sext(input logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Arithmetic shift rounds toward minus infinity.
    function automatic longint qmul(input longint a, input longint b);
        return clamp32((a * b) >>> 16);
    endfunction

    function automatic longint qdot(input longint a, b, c, d);
        return clamp32((a * b + c * d) >>> 16);
    endfunction

    function automatic longint qcross(input longint ax, ay, bx, by);
        return clamp32((ax * by - ay * bx) >>> 16);
    endfunction

    function automatic longint unsigned cap_add(input longint unsigned a, b);
        longint unsigned r;
        r = a + b;
        return (r > DEN_CAP) ? DEN_CAP : r;
    endfunction

    // Rotational term (c^2 * inverse inertia) of one body, capped.
    function automatic longint unsigned lever_term(input longint c,
                                                   input longint unsigned inertia);
        longint unsigned m, sq, r;
        m = (c < 0) ? longint'(-c) : longint'(c);
        sq = (m * m) >> 16;
        if (sq != 0 && inertia > 64'hFFFF_FFFF_FFFF_FFFF / sq) return DEN_CAP;
        r = (sq * inertia) >> 16;
        return (r > DEN_CAP) ? DEN_CAP : r;
    endfunction

    // Quotient truncates toward zero and saturates to 32 bits.
    function automatic longint impulse_quot(input longint num, input longint unsigned den);
        longint unsigned mag, q;
        mag = longint'((num < 0) ? -num : num) << 16;
        q = mag / den;
        if (num < 0) return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
        return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
    endfunction

    // Full contact resolution for one item.
    function automatic response_t resolve_contact(input contact_t c);
        response_t r;
        longint nx, ny, pax, pay, pbx, pby, ax, ay, bx, by;
        longint vax, vay, vbx, vby, wa, wb, da, db, e1, k;
        longint rax, ray, rbx, rby, rvx, rvy, tx, ty, vn, vt, jn, jt, ix, iy;
        longint unsigned ma, mb, ia, ib, sum, depth, den, emin, fmin;
        nx = sext(c.normal_xy[63:32]);  ny = sext(c.normal_xy[31:0]);
        pax = sext(c.point_a_xy[63:32]); pay = sext(c.point_a_xy[31:0]);
        pbx = sext(c.point_b_xy[63:32]); pby = sext(c.point_b_xy[31:0]);
        ax = sext(c.pos_a_xy[63:32]);   ay = sext(c.pos_a_xy[31:0]);
        bx = sext(c.pos_b_xy[63:32]);   by = sext(c.pos_b_xy[31:0]);
        vax = sext(c.vel_a_xy[63:32]);  vay = sext(c.vel_a_xy[31:0]);
        vbx = sext(c.vel_b_xy[63:32]);  vby = sext(c.vel_b_xy[31:0]);
        wa = sext(c.ang_vel_ab[63:32]); wb = sext(c.ang_vel_ab[31:0]);
        ma = c.inv_mass_ab[63:32];      mb = c.inv_mass_ab[31:0];
        ia = c.inv_inertia_ab[63:32];   ib = c.inv_inertia_ab[31:0];
        emin = (c.material_coeffs[63:48] < c.material_coeffs[47:32]) ?
               c.material_coeffs[63:48] : c.material_coeffs[47:32];
        fmin = (c.material_coeffs[31:16] < c.material_coeffs[15:0]) ?
               c.material_coeffs[31:16] : c.material_coeffs[15:0];
        depth = c.depth;
        sum = ma + mb;
        ix = 0;
        iy = 0;
        r.both_static = (sum == 0);
        if (sum != 0) begin
            da = longint'((depth * ma) / sum);
            db = longint'((depth * mb) / sum);
            // A backs off along the normal, B moves forward along it.
            ax = clamp32(ax - ((nx * da) >>> 16));
            ay = clamp32(ay - ((ny * da) >>> 16));
            bx = clamp32(bx + ((nx * db) >>> 16));
            by = clamp32(by + ((ny * db) >>> 16));
            e1 = 65536 + longint'(emin << 2);
            k = qmul(longint'(fmin << 2), e1);
            rax = clamp32(pax - ax); ray = clamp32(pay - ay);
            rbx = clamp32(pbx - bx); rby = clamp32(pby - by);
            rvx = clamp32(clamp32(vax - qmul(wa, ray)) - clamp32(vbx - qmul(wb, rby)));
            rvy = clamp32(clamp32(vay + qmul(wa, rax)) - clamp32(vby + qmul(wb, rbx)));
            tx = clamp32(-ny);
            ty = nx;
            vn = qdot(rvx, nx, rvy, ny);
            den = cap_add(cap_add(sum, lever_term(qcross(rax, ray, nx, ny), ia)),
                          lever_term(qcross(rbx, rby, nx, ny), ib));
            jn = impulse_quot(clamp32(-qmul(e1, vn)), den);
            vt = qdot(rvx, tx, rvy, ty);
            den = cap_add(cap_add(sum, lever_term(qcross(rax, ray, tx, ty), ia)),
                          lever_term(qcross(rbx, rby, tx, ty), ib));
            jt = impulse_quot(clamp32(-qmul(k, vt)), den);
            ix = clamp32(qmul(nx, jn) + qmul(tx, jt));
            iy = clamp32(qmul(ny, jn) + qmul(ty, jt));
        end
        r.pax = ax[31:0]; r.pay = ay[31:0];
        r.pbx = bx[31:0]; r.pby = by[31:0];
        r.jx = ix[31:0];  r.jy = iy[31:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation.
    // ------------------------------------------------------------------
    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    // A random signed Q16.16 value of modest magnitude, so that most
    // contacts stay out of saturation and exercise the real arithmetic.
    function automatic logic [31:0] modest_q();
        int v;
        v = int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        return v;
    endfunction

    function automatic logic [63:0] modest_pair();
        return {modest_q(), modest_q()};
    endfunction

    function automatic contact_t realistic_contact();
        contact_t c;
        int sel;
        c.normal_xy = modest_pair();
        c.depth = $urandom_range(0, 32'h0004_0000);
        c.point_a_xy = modest_pair();
        c.point_b_xy = modest_pair();
        c.pos_a_xy = modest_pair();
        c.pos_b_xy = modest_pair();
        c.vel_a_xy = modest_pair();
        c.vel_b_xy = modest_pair();
        c.ang_vel_ab = modest_pair();
        c.inv_mass_ab = {32'($urandom_range(0, 32'h0004_0000)),
                         32'($urandom_range(0, 32'h0004_0000))};
        sel = $urandom_range(0, 9);
        // Sometimes one body or both are static.
        if (sel == 0) c.inv_mass_ab[63:32] = '0;
        if (sel == 1) c.inv_mass_ab[31:0] = '0;
        if (sel == 2) c.inv_mass_ab = '0;
        c.inv_inertia_ab = {32'($urandom_range(0, 32'h0004_0000)),
                            32'($urandom_range(0, 32'h0004_0000))};
        c.material_coeffs = {16'($urandom_range(0, 16'h4000)), 16'($urandom_range(0, 16'h4000)),
                             16'($urandom_range(0, 16'h4000)), 16'($urandom_range(0, 16'h4000))};
        c.wait_drain = 1'b0;
        return c;
    endfunction

    // Every bit of every field is free, which also drives the saturation paths.
    function automatic contact_t wild_contact();
        contact_t c;
        c.normal_xy = rnd64();
        c.depth = $urandom();
        c.point_a_xy = rnd64();
        c.point_b_xy = rnd64();
        c.pos_a_xy = rnd64();
        c.pos_b_xy = rnd64();
        c.vel_a_xy = rnd64();
        c.vel_b_xy = rnd64();
        c.ang_vel_ab = rnd64();
        c.inv_mass_ab = rnd64();
        c.inv_inertia_ab = rnd64();
        c.material_coeffs = rnd64();
        c.wait_drain = 1'b0;
        return c;
    endfunction

    function automatic contact_t filled_contact(input logic [63:0] pair,
                                                input logic [31:0] dep);
        contact_t c;
        c.normal_xy = pair;
        c.depth = dep;
        c.point_a_xy = pair;
        c.point_b_xy = pair;
        c.pos_a_xy = pair;
        c.pos_b_xy = pair;
        c.vel_a_xy = pair;
        c.vel_b_xy = pair;
        c.ang_vel_ab = pair;
        c.inv_mass_ab = pair;
        c.inv_inertia_ab = pair;
        c.material_coeffs = pair;
        c.wait_drain = 1'b0;
        return c;
    endfunction

    initial begin
        contact_t c;
        // Directed part: all-zero, all-ones and sign extremes in every field.
        pending_contacts.push_back(filled_contact(64'h0, 32'h0));
        pending_contacts.push_back(filled_contact('1, '1));
        pending_contacts.push_back(filled_contact(64'h8000_0000_8000_0000, 32'hFFFF_FFFF));
        pending_contacts.push_back(filled_contact(64'h7FFF_FFFF_7FFF_FFFF, 32'hFFFF_FFFF));
        pending_contacts.push_back(filled_contact(64'h7FFF_FFFF_8000_0000, 32'h0001_0000));
        // Both bodies static: positions echo and the impulse is zero.
        c = realistic_contact();
        c.inv_mass_ab = '0;
        pending_contacts.push_back(c);
        c = wild_contact();
        c.inv_mass_ab = '0;
        pending_contacts.push_back(c);
        // Only one body static.
        c = realistic_contact();
        c.inv_mass_ab = {32'h0001_0000, 32'h0};
        pending_contacts.push_back(c);
        c = realistic_contact();
        c.inv_mass_ab = {32'h0, 32'h0001_0000};
        pending_contacts.push_back(c);
        // Unit normal, unit masses, maximum restitution and friction.
        c = realistic_contact();
        c.normal_xy = {32'h0001_0000, 32'h0};
        c.inv_mass_ab = {32'h0001_0000, 32'h0001_0000};
        c.material_coeffs = '1;
        pending_contacts.push_back(c);
        // Unnormalized normal, used as given.
        c = realistic_contact();
        c.normal_xy = {32'h0003_0000, 32'hFFFC_0000};
        pending_contacts.push_back(c);
        // Largest masses and inertias drive the denominator cap.
        c = wild_contact();
        c.inv_mass_ab = '1;
        c.inv_inertia_ab = '1;
        pending_contacts.push_back(c);
        // Zero inertias, so only the masses form the denominator.
        c = realistic_contact();
        c.inv_inertia_ab = '0;
        pending_contacts.push_back(c);
        // Zero depth and zero coefficients.
        c = realistic_contact();
        c.depth = '0;
        c.material_coeffs = '0;
        pending_contacts.push_back(c);
        // Huge velocities to saturate the impulse.
        c = realistic_contact();
        c.vel_a_xy = 64'h7FFF_FFFF_7FFF_FFFF;
        c.vel_b_xy = 64'h8000_0000_8000_0000;
        c.inv_mass_ab = {32'h0000_0001, 32'h0000_0001};
        c.inv_inertia_ab = '0;
        pending_contacts.push_back(c);
        // Random part: mostly physically sized contacts, some raw noise.
        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 3) == 0) c = wild_contact();
            else c = realistic_contact();
            pending_contacts.push_back(c);
        end
        pending_contacts[DRAIN_AT].wait_drain = 1'b1;
        total_items = pending_contacts.size();
    end

    // ------------------------------------------------------------------
    // Reset and cycle limit.
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side: acceptance is seen at the rising edge, and the driver
    // reacts at the following falling edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        in_fire <= s_valid && s_ready;
        if (s_valid && s_ready) begin
            expected_responses.push_back(resolve_contact(current));
            accepted <= accepted + 1;
        end
    end

    always @(negedge aclk) begin
        bit offer;
        bit calm;
        offer = s_valid && !in_fire;   // still holding an unaccepted item
        calm = accepted >= total_items - CALM_TAIL;
        if (aresetn && !offer) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_contacts.size() != 0 &&
                         (!pending_contacts[0].wait_drain ||
                          (expected_responses.size() == 0 && !in_fire))) begin
                current = pending_contacts.pop_front();
                s_normal_xy <= current.normal_xy;
                s_depth <= current.depth;
                s_point_a_xy <= current.point_a_xy;
                s_point_b_xy <= current.point_b_xy;
                s_pos_a_xy <= current.pos_a_xy;
                s_pos_b_xy <= current.pos_b_xy;
                s_vel_a_xy <= current.vel_a_xy;
                s_vel_b_xy <= current.vel_b_xy;
                s_ang_vel_ab <= current.ang_vel_ab;
                s_inv_mass_ab <= current.inv_mass_ab;
                s_inv_inertia_ab <= current.inv_inertia_ab;
                s_material_coeffs <= current.material_coeffs;
                offer = 1'b1;
                // Occasionally schedule an idle burst after this item.
                if (!calm && $urandom_range(0, 7) == 0)
                    send_gap <= $urandom_range(1, 9);
            end
        end
        s_valid <= offer;
    end

    // ------------------------------------------------------------------
    // Output side. The long stall runs in its own process so that the
    // block fills up and pushes back on its input.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!hold_done && accepted >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge aclk) begin
        bit calm;
        calm = accepted >= total_items - CALM_TAIL;
        if (!aresetn || hold_left > 0) begin
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 9);
        end
    end

    // Each result is compared field by field with the oldest expectation.
    always @(posedge aclk) begin
        response_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_responses.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("ERROR: result with nothing expected");
            end else begin
                want = expected_responses.pop_front();
                if (m_new_pos_a_x !== want.pax || m_new_pos_a_y !== want.pay ||
                    m_new_pos_b_x !== want.pbx || m_new_pos_b_y !== want.pby ||
                    m_impulse_x !== want.jx || m_impulse_y !== want.jy ||
                    m_both_static !== want.both_static) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) begin
                        $display("ERROR: expected pa=%h,%h pb=%h,%h j=%h,%h st=%b",
                                 want.pax, want.pay, want.pbx, want.pby,
                                 want.jx, want.jy, want.both_static);
                        $display("       actual   pa=%h,%h pb=%h,%h j=%h,%h st=%b",
                                 m_new_pos_a_x, m_new_pos_a_y, m_new_pos_b_x,
                                 m_new_pos_b_y, m_impulse_x, m_impulse_y, m_both_static);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // End of run: everything sent, every result in, then a quiet stretch
    // longer than the pipeline so that a stray extra result is caught.
    // ------------------------------------------------------------------
    initial begin
        wait (total_items > 0);
        wait (accepted == total_items && expected_responses.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && expected_responses.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cir_pkg.sv
rtl/cir_front.sv
rtl/cir_fifo.sv
rtl/cir_div.sv
rtl/cir_back.sv
rtl/contact_impulse_resolver_top.sv
tb/sv/testbench.sv
